@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the event ring mouse consumer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define XERM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define XERM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/xerm_pkg.sv @@
// ----------------------------------------------------------------------------
// xerm_pkg
// Types and constants shared by the event ring mouse consumer modules.
// ----------------------------------------------------------------------------
package xerm_pkg;

  // Result kinds, carried on the result channel's tuser.
  typedef enum logic [1:0] {
    KIND_RESUBMIT = 2'd0,
    KIND_DEQUEUE  = 2'd1,
    KIND_REPORT   = 2'd2
  } result_kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] CFG_EVENT_RING_BASE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MOUSE_SLOT      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPORT_SINK     = 2'd2;

  // Event decoding constants.
  localparam logic [5:0]  EVT_TYPE_TRANSFER       = 6'd32;
  localparam logic [4:0]  MOUSE_ENDPOINT_ID       = 5'd3;
  localparam logic [7:0]  CC_SUCCESS              = 8'd1;
  localparam logic [7:0]  CC_SHORT_PACKET         = 8'd13;
  localparam logic [7:0]  MOUSE_REPORT_ID         = 8'd1;
  localparam logic [23:0] REPORT_ID_MAX_REMAINING = 24'd4;

  // Event handler busy flag ORed into the dequeue pointer.
  localparam logic [63:0] ERDP_BUSY_FLAG = 64'h8;

  // Result queue depth, in input items.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  typedef struct packed {
    logic        cycle_bit;
    logic [5:0]  entry_type;
    logic [7:0]  slot_id;
    logic [4:0]  endpoint_id;
    logic [7:0]  comp_code;
    logic [23:0] remaining_len;
    logic [7:0]  report_byte0;
    logic [7:0]  report_byte1;
    logic [7:0]  report_byte2;
    logic [7:0]  report_byte3;
  } event_item_t;

  typedef struct packed {
    logic              hit;
    logic [7:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } mouse_evt_t;

  typedef struct packed {
    result_kind_t       kind;
    logic [7:0]         ring_index;
    logic               ring_cycle;
    logic               link_wrapped;
    logic [63:0]        pointer_value;
    logic signed [14:0] move_x;
    logic signed [14:0] move_y;
    logic [7:0]         buttons;
    logic               last;
  } result_t;

  // All results of one input item: one or two.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } queue_entry_t;

endpackage

@@ rtl/xerm_report_decode.sv @@
// ----------------------------------------------------------------------------
// xerm_report_decode
// Recognizes a mouse transfer event and extracts buttons and deltas.
// ----------------------------------------------------------------------------
module xerm_report_decode (
  input  xerm_pkg::event_item_t item,
  input  logic [7:0]            mouse_slot,
  output xerm_pkg::mouse_evt_t  evt
);
  import xerm_pkg::*;

  logic has_report_id;
  logic code_ok;

  // A report ID byte is present only when at least four bytes arrived.
  assign has_report_id = (item.report_byte0 == MOUSE_REPORT_ID) &&
                         (item.remaining_len <= REPORT_ID_MAX_REMAINING);
  assign code_ok = (item.comp_code == CC_SUCCESS) ||
                   (item.comp_code == CC_SHORT_PACKET);

  always_comb begin
    evt.hit = (item.entry_type == EVT_TYPE_TRANSFER) &&
              (item.slot_id == mouse_slot) &&
              (item.endpoint_id == MOUSE_ENDPOINT_ID) && code_ok;
    if (has_report_id) begin
      evt.buttons = item.report_byte1;
      evt.dx      = item.report_byte2;
      evt.dy      = item.report_byte3;
    end else begin
      evt.buttons = item.report_byte0;
      evt.dx      = item.report_byte1;
      evt.dy      = item.report_byte2;
    end
  end

endmodule

@@ rtl/xerm_result_queue.sv @@
// ----------------------------------------------------------------------------
// xerm_result_queue
// Small queue of per-item result groups, delivered one result per request.
// ----------------------------------------------------------------------------
module xerm_result_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  xerm_pkg::queue_entry_t               push_entry,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output xerm_pkg::result_t                    out_result,
  output logic [xerm_pkg::QUEUE_CNT_W-1:0]     count
);
  import xerm_pkg::*;

  queue_entry_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   sub_r, sub_nxt;
  logic                   pop;
  queue_entry_t           head;

  assign head       = mem_r[rd_ptr_r];
  assign out_valid  = (count_r != '0);
  assign out_result = sub_r ? head.second : head.first;
  assign count      = count_r;

  // The head entry leaves once its final result has been taken.
  assign pop = out_valid && out_ready && (sub_r || !head.two);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    sub_nxt    = sub_r;
    if (out_valid && out_ready) begin
      sub_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/xhci_event_ring_mouse_consumer_unit.sv @@
// ----------------------------------------------------------------------------
// xhci_event_ring_mouse_consumer_unit
// xHCI event ring consumer with a boot-protocol mouse report decoder.
// ----------------------------------------------------------------------------
// The block takes one event ring entry per clock (with the first four bytes of
// the mouse report buffer it points to) and keeps the consumer side of the
// ring: dequeue index, consumer cycle state, per-poll movement sums and the
// transfer ring position for resubmitted reads. An accepted entry is held in
// an input register, decoded and applied to the state by a single level of
// logic, and its results (none, one or two) are written as one group into a
// four-entry result queue, so results appear at the earliest once the entry
// has gone through the input register and the queue. The sustained rate is one
// entry per cycle as long as the result side keeps up; an entry with two
// results delivers them one after the other on the result channel, and the
// input side stalls only when the result queue is close to full. Writing a
// zero ring base turns all processing off: entries are still accepted but
// ignored. Configuration must be written only while no entry is in flight.
// ----------------------------------------------------------------------------
module xhci_event_ring_mouse_consumer_unit #(
  parameter int unsigned EVENT_RING_ENTRIES  = 256,
  parameter int unsigned TRANSFER_RING_SLOTS = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,

  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [xerm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [xerm_pkg::CFG_DATA_W-1:0]     cfg_wdata,

  // Event entry requests.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Low to high: cycle_bit, slot_id, endpoint_id, comp_code,
  // remaining_len, report_byte0, report_byte1, report_byte2, report_byte3, pad.
  input  logic [79:0]                         in_tdata,
  // entry_type.
  input  logic [5:0]                          in_tuser,

  // Result requests.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Low to high: ring_index, ring_cycle, link_wrapped, pointer_value,
  // move_x, move_y, buttons.
  output logic [111:0]                        out_tdata,
  // result_kind.
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);
  import xerm_pkg::*;

  localparam int unsigned EIDX_W = $clog2(EVENT_RING_ENTRIES);
  localparam int unsigned TIDX_W = $clog2(TRANSFER_RING_SLOTS);

  // Configuration registers.
  logic [63:0] ring_base_r;
  logic [7:0]  mouse_slot_r;
  logic        sink_en_r;

  // Input register.
  logic        item_valid_r, item_valid_nxt;
  event_item_t item_r;
  event_item_t in_item;

  // Consumer state.
  logic [EIDX_W-1:0] deq_idx_r, deq_idx_nxt;
  logic [EIDX_W-1:0] poll_start_r, poll_start_nxt;
  logic              event_cycle_r, event_cycle_nxt;
  logic signed [15:0] sum_x_r, sum_x_nxt;
  logic signed [15:0] sum_y_r, sum_y_nxt;
  logic [7:0]        btn_acc_r, btn_acc_nxt;
  logic              seen_r, seen_nxt;
  logic [TIDX_W-1:0] xfer_idx_r, xfer_idx_nxt;
  logic              xfer_cycle_r, xfer_cycle_nxt;

  // Processing signals.
  mouse_evt_t         evt;
  logic               active;
  logic               cycle_match;
  logic [EIDX_W:0]    deq_inc;
  logic [TIDX_W:0]    xfer_inc;
  logic               xfer_wrap;
  logic signed [16:0] add_x, add_y;
  logic signed [15:0] half_x, half_y;
  logic               emit_dequeue, emit_report;
  result_t            res_resubmit, res_dequeue, res_report;
  logic               push;
  queue_entry_t       push_entry;
  logic [QUEUE_CNT_W-1:0] q_count;
  result_t            out_result;

  // --------------------------------------------------------------------------
  // Configuration.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_base_r  <= '0;
      mouse_slot_r <= '0;
      sink_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EVENT_RING_BASE: ring_base_r  <= cfg_wdata;
        CFG_MOUSE_SLOT:      mouse_slot_r <= cfg_wdata[7:0];
        CFG_REPORT_SINK:     sink_en_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The processing stage drains every cycle, so a request is
  // taken whenever the queue can still hold the group of the item now in the
  // stage plus one more.
  // --------------------------------------------------------------------------
  assign in_tready = (q_count + QUEUE_CNT_W'(item_valid_r)) <=
                     QUEUE_CNT_W'(QUEUE_DEPTH - 1);

  assign in_item.cycle_bit     = in_tdata[0];
  assign in_item.entry_type    = in_tuser;
  assign in_item.slot_id       = in_tdata[8:1];
  assign in_item.endpoint_id   = in_tdata[13:9];
  assign in_item.comp_code     = in_tdata[21:14];
  assign in_item.remaining_len = in_tdata[45:22];
  assign in_item.report_byte0  = in_tdata[53:46];
  assign in_item.report_byte1  = in_tdata[61:54];
  assign in_item.report_byte2  = in_tdata[69:62];
  assign in_item.report_byte3  = in_tdata[77:70];

  assign item_valid_nxt = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_nxt) begin
      item_r <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Processing stage.
  // --------------------------------------------------------------------------
  xerm_report_decode u_decode (
    .item       (item_r),
    .mouse_slot (mouse_slot_r),
    .evt        (evt)
  );

  assign active      = item_valid_r && (ring_base_r != '0);
  assign cycle_match = (item_r.cycle_bit == event_cycle_r);

  assign deq_inc   = {1'b0, deq_idx_r} + 1'b1;
  assign xfer_inc  = {1'b0, xfer_idx_r} + 1'b1;
  assign xfer_wrap = (xfer_inc >= (TIDX_W + 1)'(TRANSFER_RING_SLOTS));

  // Sign-extended sums; saturate where the top two bits disagree.
  assign add_x = {sum_x_r[15], sum_x_r} + 17'(evt.dx);
  assign add_y = {sum_y_r[15], sum_y_r} + 17'(evt.dy);

  // Halving rounds toward zero: add one to a negative sum before the shift.
  assign half_x = (sum_x_r + 16'(sum_x_r[15])) >>> 1;
  assign half_y = (sum_y_r + 16'(sum_y_r[15])) >>> 1;

  // A full lap within one poll leaves the index unchanged and is not reported.
  assign emit_dequeue = (deq_idx_r != poll_start_r);
  assign emit_report  = seen_r && sink_en_r &&
                        ((half_x != '0) || (half_y != '0) || (btn_acc_r != '0));

  always_comb begin
    res_resubmit               = '0;
    res_resubmit.kind          = KIND_RESUBMIT;
    res_resubmit.ring_index    = 8'(xfer_idx_r);
    res_resubmit.ring_cycle    = xfer_cycle_r;
    res_resubmit.link_wrapped  = xfer_wrap;
    res_resubmit.last          = 1'b1;

    res_dequeue                = '0;
    res_dequeue.kind           = KIND_DEQUEUE;
    res_dequeue.ring_index     = 8'(deq_idx_r);
    res_dequeue.pointer_value  = (ring_base_r + (64'(deq_idx_r) << 4)) | ERDP_BUSY_FLAG;
    res_dequeue.last           = !emit_report;

    res_report                 = '0;
    res_report.kind            = KIND_REPORT;
    res_report.move_x          = half_x[14:0];
    res_report.move_y          = half_y[14:0];
    res_report.buttons         = btn_acc_r;
    res_report.last            = 1'b1;
  end

  always_comb begin
    deq_idx_nxt     = deq_idx_r;
    poll_start_nxt  = poll_start_r;
    event_cycle_nxt = event_cycle_r;
    sum_x_nxt       = sum_x_r;
    sum_y_nxt       = sum_y_r;
    btn_acc_nxt     = btn_acc_r;
    seen_nxt        = seen_r;
    xfer_idx_nxt    = xfer_idx_r;
    xfer_cycle_nxt  = xfer_cycle_r;
    push            = 1'b0;
    push_entry      = '0;

    if (active) begin
      if (cycle_match) begin
        // Consume the entry.
        if (evt.hit) begin
          if (add_x[16] != add_x[15]) begin
            sum_x_nxt = add_x[16] ? 16'sh8000 : 16'sh7FFF;
          end else begin
            sum_x_nxt = add_x[15:0];
          end
          if (add_y[16] != add_y[15]) begin
            sum_y_nxt = add_y[16] ? 16'sh8000 : 16'sh7FFF;
          end else begin
            sum_y_nxt = add_y[15:0];
          end
          btn_acc_nxt = btn_acc_r | evt.buttons;
          seen_nxt    = 1'b1;

          // A slot of zero means no device to resubmit to.
          if (mouse_slot_r != '0) begin
            if (xfer_wrap) begin
              xfer_idx_nxt   = '0;
              xfer_cycle_nxt = !xfer_cycle_r;
            end else begin
              xfer_idx_nxt = xfer_inc[TIDX_W-1:0];
            end
            push             = 1'b1;
            push_entry.first = res_resubmit;
          end
        end

        if (deq_inc >= (EIDX_W + 1)'(EVENT_RING_ENTRIES)) begin
          deq_idx_nxt     = '0;
          event_cycle_nxt = !event_cycle_r;
        end else begin
          deq_idx_nxt = deq_inc[EIDX_W-1:0];
        end
      end else begin
        // End of poll: report the dequeue pointer and what moved, then start a fresh poll.
        push              = emit_dequeue || emit_report;
        push_entry.two    = emit_dequeue && emit_report;
        push_entry.first  = emit_dequeue ? res_dequeue : res_report;
        push_entry.second = res_report;

        poll_start_nxt = deq_idx_r;
        sum_x_nxt      = '0;
        sum_y_nxt      = '0;
        btn_acc_nxt    = '0;
        seen_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deq_idx_r     <= '0;
      poll_start_r  <= '0;
      event_cycle_r <= 1'b1;
      sum_x_r       <= '0;
      sum_y_r       <= '0;
      btn_acc_r     <= '0;
      seen_r        <= 1'b0;
      xfer_idx_r    <= '0;
      xfer_cycle_r  <= 1'b1;
    end else begin
      deq_idx_r     <= deq_idx_nxt;
      poll_start_r  <= poll_start_nxt;
      event_cycle_r <= event_cycle_nxt;
      sum_x_r       <= sum_x_nxt;
      sum_y_r       <= sum_y_nxt;
      btn_acc_r     <= btn_acc_nxt;
      seen_r        <= seen_nxt;
      xfer_idx_r    <= xfer_idx_nxt;
      xfer_cycle_r  <= xfer_cycle_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue and output packing.
  // --------------------------------------------------------------------------
  xerm_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result),
    .count      (q_count)
  );

  assign out_tuser = out_result.kind;
  assign out_tlast = out_result.last;
  assign out_tdata = {out_result.buttons,
                      out_result.move_y,
                      out_result.move_x,
                      out_result.pointer_value,
                      out_result.link_wrapped,
                      out_result.ring_cycle,
                      out_result.ring_index};

endmodule

@@ rtl/xerm_checker.sv @@
// ----------------------------------------------------------------------------
// xerm_checker
// Port-level checks for the event ring mouse consumer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xerm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import xerm_pkg::*;

  // A result offered but not taken is still offered in the next cycle.
  `XERM_ASSERT_CLK(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid,
    "result dropped while stalled")

  // A resubmit request never carries a dequeue pointer.
  `XERM_ASSERT_CLK(a_resubmit_no_ptr, clk, rst_n,
    out_tvalid && (out_tuser == KIND_RESUBMIT) |-> (out_tdata[73:10] == '0),
    "resubmit request carries a pointer")

  // A movement report is always the final result of its request.
  `XERM_ASSERT_CLK(a_report_last, clk, rst_n,
    out_tvalid && (out_tuser == KIND_REPORT) |-> out_tlast,
    "movement report not marked last")

  // Nothing is offered right after a reset cycle.
  `XERM_ASSERT_ALWAYS(a_reset_empty, clk,
    !rst_n |=> !out_tvalid,
    "result offered after reset")

endmodule

bind xhci_event_ring_mouse_consumer_unit xerm_checker u_xerm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
